/* rtl/lmfc_pkg.sv */
// shared types, constants and mode rules of the lamp mode and fade controller
`timescale 1ns / 1ps
`default_nettype none

package lmfc_pkg;

  localparam int unsigned FADE_STEPS_DEF = 32;

  localparam logic [7:0]  LEVEL_HIGH_RST = 8'd255;
  localparam logic [7:0]  LEVEL_MID_RST  = 8'd127;
  localparam logic [7:0]  LEVEL_LOW_RST  = 8'd63;
  localparam logic [30:0] TIMEOUT_RST    = 31'd10000000;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 31;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_LEVEL_HIGH = 2'd0;
  localparam cfg_idx_t CFG_LEVEL_MID  = 2'd1;
  localparam cfg_idx_t CFG_LEVEL_LOW  = 2'd2;
  localparam cfg_idx_t CFG_TIMEOUT    = 2'd3;

  typedef enum logic [2:0] {
    MODE_OFF      = 3'd0,
    MODE_HIGH     = 3'd1,
    MODE_MID      = 3'd2,
    MODE_LOW      = 3'd3,
    MODE_AUTO     = 3'd4,
    MODE_AUTO_OFF = 3'd5
  } mode_t;

  typedef logic [2:0][7:0] rgb_t;

  typedef struct packed {
    mode_t      mode;
    logic       armed;
    logic       stamp_load;
    logic       fade_begin;
    logic [7:0] gray;
  } rules_t;

  // one pass of the six-mode rules
  function automatic rules_t lmfc_rules(input mode_t mode, input logic armed,
                                        input logic phone, input logic button,
                                        input logic [7:0] lvl_high,
                                        input logic [7:0] lvl_mid,
                                        input logic [7:0] lvl_low);
    rules_t r;
    r.mode       = mode;
    r.armed      = armed;
    r.stamp_load = 1'b0;
    r.fade_begin = 1'b0;
    r.gray       = 8'd0;
    unique case (mode)
      MODE_OFF: begin
        if (phone) begin
          r.mode = MODE_AUTO;
        end else if (button) begin
          r.mode       = MODE_HIGH;
          r.fade_begin = 1'b1;
          r.gray       = lvl_high;
        end
      end
      MODE_HIGH: begin
        if (phone) begin
          r.mode = MODE_AUTO;
        end else if (button) begin
          r.mode       = MODE_MID;
          r.fade_begin = 1'b1;
          r.gray       = lvl_mid;
        end
      end
      MODE_MID: begin
        if (button) begin
          r.mode       = MODE_LOW;
          r.fade_begin = 1'b1;
          r.gray       = lvl_low;
        end else if (phone) begin
          r.mode = MODE_AUTO;
        end
      end
      MODE_LOW: begin
        if (button) begin
          r.mode       = MODE_OFF;
          r.fade_begin = 1'b1;
          r.gray       = 8'd0;
        end else if (phone) begin
          r.mode = MODE_AUTO;
        end
      end
      MODE_AUTO: begin
        if (!phone) begin
          r.mode       = MODE_AUTO_OFF;
          r.armed      = 1'b1;
          r.stamp_load = 1'b1;
        end
      end
      MODE_AUTO_OFF: begin
        if (phone) begin
          r.mode  = MODE_AUTO;
          r.armed = 1'b0;
        end else if (button) begin
          r.mode       = MODE_OFF;
          r.armed      = 1'b0;
          r.fade_begin = 1'b1;
          r.gray       = 8'd0;
        end
      end
      default: begin
        r.mode = MODE_OFF;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/lmfc_if.sv */
// valid/ready channel interfaces for control passes and their results
`timescale 1ns / 1ps
`default_nettype none

interface lmfc_in_if;
  logic        valid;
  logic        ready;
  logic        phone_present;
  logic        button_press;
  logic [31:0] now_us;

  modport source (output valid, output phone_present, output button_press,
                  output now_us, input ready);
  modport sink   (input valid, input phone_present, input button_press,
                  input now_us, output ready);
endinterface

interface lmfc_out_if import lmfc_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  mode_t      mode;
  logic       color_updated;

  modport source (output valid, output red, output green, output blue,
                  output mode, output color_updated, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input mode, input color_updated, output ready);
endinterface

`default_nettype wire

/* rtl/lamp_mode_fade_controller.sv */
// lamp mode and fade controller: mode rules, auto-off timer and fade stepping
// a pass is held in the input register, and its result is registered at the output
// throughput: one pass per cycle unless the result side stalls; all rules and the fade step sit in one stage
// the fade divide by FADE_STEPS is a running sum times a constant reciprocal
// reset (synchronous, rst_n low): mode off, color black, fade at its last step,
// timer disarmed, levels 255/127/63 and timeout 10000000 us
`timescale 1ns / 1ps
`default_nettype none

module lamp_mode_fade_controller import lmfc_pkg::*; #(
  parameter int unsigned FADE_STEPS = FADE_STEPS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  lmfc_in_if.sink                in_ch,
  lmfc_out_if.source             out_ch,
  input  wire logic              cfg_we,
  input  wire cfg_idx_t          cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned LOG_N   = $clog2(FADE_STEPS);
  localparam int unsigned STEP_W  = $clog2(FADE_STEPS + 1);
  localparam int unsigned MAG_W   = LOG_N + 8;
  localparam int unsigned ACC_W   = LOG_N + 9;
  localparam int unsigned SHIFT   = MAG_W + LOG_N;
  localparam int unsigned PROD_W  = MAG_W + SHIFT;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(FADE_STEPS) - 64'd1) / 64'(FADE_STEPS);
  localparam logic [SHIFT-1:0] RECIP = RECIP_FULL[SHIFT-1:0];
  localparam logic [STEP_W-1:0] STEP_END  = STEP_W'(FADE_STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(FADE_STEPS - 1);

  typedef struct packed {
    logic        phone;
    logic        button;
    logic [31:0] now;
  } pass_t;

  typedef struct packed {
    rgb_t  color;
    mode_t mode;
    logic  updated;
  } result_t;

  // configuration
  logic [7:0]  level_high_r;
  logic [7:0]  level_mid_r;
  logic [7:0]  level_low_r;
  logic [30:0] timeout_r;

  // channel stages
  logic    in_valid_r;
  pass_t   in_r;
  logic    out_valid_r;
  result_t out_r;
  logic    adv;

  // lamp state
  mode_t                  mode_r;
  logic                   armed_r;
  logic [31:0]            stamp_r;
  rgb_t                   color_r;
  rgb_t                   start_r;
  rgb_t                   target_r;
  logic [STEP_W-1:0]      step_r;
  logic [2:0][ACC_W-1:0]  acc_r;

  // next state
  rules_t                 r1;
  rules_t                 r2;
  logic [31:0]            stamp1;
  logic [31:0]            elapsed;
  logic                   timeout_hit;
  mode_t                  mode_nxt;
  logic                   armed_nxt;
  logic [31:0]            stamp_nxt;
  logic                   begin_c;
  logic [7:0]             gray_c;
  logic [STEP_W-1:0]      step_eff;
  logic                   emit_c;
  logic                   last_c;
  logic [STEP_W-1:0]      step_nxt;
  rgb_t                   color_nxt;
  rgb_t                   start_nxt;
  rgb_t                   target_nxt;
  logic [2:0][ACC_W-1:0]  acc_nxt;
  logic [2:0][8:0]        diff_c;
  logic [2:0][ACC_W-1:0]  acc_eff;
  logic [2:0][ACC_W-1:0]  abs_c;
  logic [2:0][MAG_W-1:0]  mag_c;
  logic [2:0][PROD_W-1:0] prod_c;
  logic [2:0][7:0]        qmag_c;
  logic [2:0][8:0]        quot_c;
  logic [2:0][9:0]        sum_c;
  logic [2:0]             neg_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_high_r <= LEVEL_HIGH_RST;
      level_mid_r  <= LEVEL_MID_RST;
      level_low_r  <= LEVEL_LOW_RST;
      timeout_r    <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_LEVEL_HIGH: level_high_r <= cfg_wdata[7:0];
        CFG_LEVEL_MID:  level_mid_r  <= cfg_wdata[7:0];
        CFG_LEVEL_LOW:  level_low_r  <= cfg_wdata[7:0];
        CFG_TIMEOUT:    timeout_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign adv          = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_r <= '{phone: in_ch.phone_present, button: in_ch.button_press,
                now: in_ch.now_us};
    end
  end

  always_comb begin
    r1 = lmfc_rules(mode_r, armed_r, in_r.phone, in_r.button,
                    level_high_r, level_mid_r, level_low_r);
    stamp1      = r1.stamp_load ? in_r.now : stamp_r;
    elapsed     = in_r.now - stamp1;
    timeout_hit = r1.armed && (elapsed > {1'b0, timeout_r});
    // forced press after the auto-off wait
    r2 = lmfc_rules(r1.mode, r1.armed, in_r.phone, 1'b1,
                    level_high_r, level_mid_r, level_low_r);
    if (timeout_hit) begin
      mode_nxt  = r2.mode;
      armed_nxt = r2.armed;
      stamp_nxt = r2.stamp_load ? in_r.now : stamp1;
      begin_c   = r1.fade_begin || r2.fade_begin;
      gray_c    = r2.fade_begin ? r2.gray : r1.gray;
    end else begin
      mode_nxt  = r1.mode;
      armed_nxt = r1.armed;
      stamp_nxt = stamp1;
      begin_c   = r1.fade_begin;
      gray_c    = r1.gray;
    end

    step_eff = begin_c ? '0 : step_r;
    emit_c   = step_eff < STEP_END;
    last_c   = step_eff >= STEP_LAST;
    step_nxt = emit_c ? step_eff + 1'b1 : step_eff;

    for (int c = 0; c < 3; c++) begin
      start_nxt[c]  = begin_c ? color_r[c] : start_r[c];
      target_nxt[c] = begin_c ? gray_c : target_r[c];
      diff_c[c]     = {1'b0, target_nxt[c]} - {1'b0, start_nxt[c]};
      acc_eff[c]    = begin_c ? '0 : acc_r[c];
      // truncating signed divide by the step count
      neg_c[c]      = acc_eff[c][ACC_W-1];
      abs_c[c]      = neg_c[c] ? (~acc_eff[c] + 1'b1) : acc_eff[c];
      mag_c[c]      = abs_c[c][MAG_W-1:0];
      prod_c[c]     = PROD_W'(mag_c[c]) * PROD_W'(RECIP);
      qmag_c[c]     = prod_c[c][SHIFT+7:SHIFT];
      quot_c[c]     = neg_c[c] ? (~{1'b0, qmag_c[c]} + 1'b1) : {1'b0, qmag_c[c]};
      sum_c[c]      = {2'b00, start_nxt[c]} + {quot_c[c][8], quot_c[c]};
      if (emit_c) begin
        color_nxt[c] = last_c ? target_nxt[c] : sum_c[c][7:0];
        acc_nxt[c]   = acc_eff[c] + {{(ACC_W-9){diff_c[c][8]}}, diff_c[c]};
      end else begin
        color_nxt[c] = color_r[c];
        acc_nxt[c]   = acc_eff[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_OFF;
      armed_r  <= 1'b0;
      stamp_r  <= '0;
      color_r  <= '0;
      start_r  <= '0;
      target_r <= '0;
      step_r   <= STEP_LAST;
      acc_r    <= '0;
    end else if (adv) begin
      mode_r   <= mode_nxt;
      armed_r  <= armed_nxt;
      stamp_r  <= stamp_nxt;
      color_r  <= color_nxt;
      start_r  <= start_nxt;
      target_r <= target_nxt;
      step_r   <= step_nxt;
      acc_r    <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= '{color: color_nxt, mode: mode_nxt, updated: emit_c};
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.red           = out_r.color[0];
  assign out_ch.green         = out_r.color[1];
  assign out_ch.blue          = out_r.color[2];
  assign out_ch.mode          = out_r.mode;
  assign out_ch.color_updated = out_r.updated;

`ifndef ASSERT_OFF
  a_armed_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    armed_r |-> (mode_r == MODE_AUTO_OFF))
    else $error("timer armed outside auto-off waiting");

  a_step_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= STEP_END)
    else $error("fade step counter past the end");

  a_color_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !emit_c) |=> $stable(color_r))
    else $error("color changed on a pass without a fade step");

  a_pass_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !adv) |=> (in_valid_r && $stable(in_r)))
    else $error("stalled pass lost or changed");
`endif

endmodule

`default_nettype wire

/* dv/lmfc_fade_checker.sv */
// checker for the lamp controller: predicts every pass result and compares it with the output
`timescale 1ns / 1ps

module lmfc_fade_checker import lmfc_pkg::*; #(
  parameter int unsigned FADE_STEPS = FADE_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lmfc_in_if                    in_ch,
  lmfc_out_if                   out_ch,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);

  localparam int STEPS_I = int'(FADE_STEPS);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    mode_t      mode;
    logic       upd;
  } lamp_view_t;

  lamp_view_t expected_views[$];
  lamp_view_t want;
  lamp_view_t view;

  mode_t       lamp_mode;
  logic [7:0]  lvl_high;
  logic [7:0]  lvl_mid;
  logic [7:0]  lvl_low;
  logic [30:0] off_wait;
  logic [7:0]  shown[3];
  logic [7:0]  fade_from[3];
  logic [7:0]  fade_to[3];
  logic [8:0]  step_idx;
  logic        timer_on;
  logic [31:0] timer_mark;

  function automatic logic [7:0] fade_level(input logic [7:0] src, input logic [7:0] dst,
                                            input logic [8:0] k);
    int span;
    int v;
    if (k >= FADE_STEPS - 1) return dst;
    span = int'(dst) - int'(src);
    v = int'(src) + (int'(k) * span) / STEPS_I;
    return v[7:0];
  endfunction

  task automatic start_fade(input logic [7:0] gray);
    for (int c = 0; c < 3; c++) begin
      fade_from[c] = shown[c];
      fade_to[c]   = gray;
    end
    step_idx = '0;
  endtask

  task automatic run_modes(input logic phone, input logic button, input logic [31:0] now);
    case (lamp_mode)
      MODE_OFF: begin
        if (phone) begin
          lamp_mode = MODE_AUTO;
        end else if (button) begin
          lamp_mode = MODE_HIGH;
          start_fade(lvl_high);
        end
      end
      MODE_HIGH: begin
        if (phone) begin
          lamp_mode = MODE_AUTO;
        end else if (button) begin
          lamp_mode = MODE_MID;
          start_fade(lvl_mid);
        end
      end
      MODE_MID: begin
        if (phone) lamp_mode = MODE_AUTO;
        if (button) begin
          lamp_mode = MODE_LOW;
          start_fade(lvl_low);
        end
      end
      MODE_LOW: begin
        if (phone) lamp_mode = MODE_AUTO;
        if (button) begin
          lamp_mode = MODE_OFF;
          start_fade(8'd0);
        end
      end
      MODE_AUTO: begin
        if (!phone) begin
          lamp_mode  = MODE_AUTO_OFF;
          timer_on   = 1'b1;
          timer_mark = now;
        end
      end
      MODE_AUTO_OFF: begin
        if (phone) begin
          timer_on  = 1'b0;
          lamp_mode = MODE_AUTO;
        end else if (button) begin
          timer_on  = 1'b0;
          lamp_mode = MODE_OFF;
          start_fade(8'd0);
        end
      end
      default: begin
        lamp_mode = MODE_OFF;
      end
    endcase
  endtask

  task automatic predict_pass(input logic phone, input logic button, input logic [31:0] now,
                              output lamp_view_t res);
    logic [31:0] waited;
    run_modes(phone, button, now);
    waited = now - timer_mark;
    // auto-off timeout acts as a forced button press
    if (timer_on && waited > {1'b0, off_wait}) run_modes(phone, 1'b1, now);
    res.upd = 1'b0;
    if (step_idx < FADE_STEPS) begin
      for (int c = 0; c < 3; c++) shown[c] = fade_level(fade_from[c], fade_to[c], step_idx);
      step_idx = step_idx + 9'd1;
      res.upd  = 1'b1;
    end
    res.red   = shown[0];
    res.green = shown[1];
    res.blue  = shown[2];
    res.mode  = lamp_mode;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      lamp_mode  = MODE_OFF;
      lvl_high   = LEVEL_HIGH_RST;
      lvl_mid    = LEVEL_MID_RST;
      lvl_low    = LEVEL_LOW_RST;
      off_wait   = TIMEOUT_RST;
      for (int c = 0; c < 3; c++) begin
        shown[c]     = 8'd0;
        fade_from[c] = 8'd0;
        fade_to[c]   = 8'd0;
      end
      step_idx   = 9'(FADE_STEPS - 1);
      timer_on   = 1'b0;
      timer_mark = '0;
      fail_count = 0;
      expected_views.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_views.size() == 0) begin
          if (fail_count < 10)
            $display("lmfc_fade_checker: unexpected result rgb %0d/%0d/%0d mode %0d upd %0b",
                     out_ch.red, out_ch.green, out_ch.blue, out_ch.mode,
                     out_ch.color_updated);
          fail_count++;
        end else begin
          want = expected_views.pop_front();
          if (out_ch.red !== want.red || out_ch.green !== want.green ||
              out_ch.blue !== want.blue || out_ch.mode !== want.mode ||
              out_ch.color_updated !== want.upd) begin
            if (fail_count < 10)
              $display({"lmfc_fade_checker: mismatch, expected rgb %0d/%0d/%0d mode %0d ",
                        "upd %0b, got rgb %0d/%0d/%0d mode %0d upd %0b"},
                       want.red, want.green, want.blue, want.mode, want.upd,
                       out_ch.red, out_ch.green, out_ch.blue, out_ch.mode,
                       out_ch.color_updated);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_LEVEL_HIGH: lvl_high = cfg_wdata[7:0];
          CFG_LEVEL_MID:  lvl_mid  = cfg_wdata[7:0];
          CFG_LEVEL_LOW:  lvl_low  = cfg_wdata[7:0];
          CFG_TIMEOUT:    off_wait = cfg_wdata[30:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_pass(in_ch.phone_present, in_ch.button_press, in_ch.now_us, view);
        expected_views.push_back(view);
      end
    end
    pending = expected_views.size();
  end

endmodule

/* dv/tb_top.sv */
// top of the lamp controller testbench: clock, reset, pass stimulus, register writes, verdict
`timescale 1ns / 1ps

module tb_top import lmfc_pkg::*;;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  cfg_idx_t              cfg_idx = CFG_LEVEL_HIGH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    fail_count;
  int                    pending;

  logic [30:0] cur_timeout = TIMEOUT_RST;
  logic [31:0] clock_us = '0;
  logic        phone_held = 1'b0;
  bit          hold_req = 1'b0;

  lmfc_in_if  in_ch ();
  lmfc_out_if out_ch ();

  lamp_mode_fade_controller u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  lmfc_fade_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // result side: random stall patterns plus one long hold-off on request
  initial begin
    int style;
    int len;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (120) @(posedge clk);
      end else begin
        style = $urandom_range(0, 2);
        len   = $urandom_range(1, 40);
        repeat (len) begin
          case (style)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= 1'($urandom_range(0, 1));
            default: out_ch.ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  task automatic drive_pass(input logic phone, input logic button, input logic [31:0] now);
    in_ch.valid         <= 1'b1;
    in_ch.phone_present <= phone;
    in_ch.button_press  <= button;
    in_ch.now_us        <= now;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [30:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // level registers get random upper bits, only the low byte counts
  task automatic set_regs(input logic [7:0] hi, input logic [7:0] mid, input logic [7:0] lo,
                          input logic [30:0] tmo);
    write_reg(CFG_LEVEL_HIGH, {23'($urandom), hi});
    write_reg(CFG_LEVEL_MID, {23'($urandom), mid});
    write_reg(CFG_LEVEL_LOW, {23'($urandom), lo});
    write_reg(CFG_TIMEOUT, tmo);
    cfg_we      <= 1'b0;
    cur_timeout = tmo;
  endtask

  task automatic random_pass(input int btn_pct);
    int   pick;
    logic btn;
    if ($urandom_range(0, 99) < 12) phone_held = ~phone_held;
    btn  = ($urandom_range(0, 99) < btn_pct);
    pick = $urandom_range(0, 99);
    // time steps: short, right around the timeout, large, or anywhere
    if (pick < 55)      clock_us = clock_us + $urandom_range(0, 40);
    else if (pick < 80) clock_us = clock_us + {1'b0, cur_timeout} + $urandom_range(0, 2) - 1;
    else if (pick < 92) clock_us = clock_us + $urandom;
    else                clock_us = $urandom;
    drive_pass(phone_held, btn, clock_us);
  endtask

  task automatic run_random(input int n_items);
    int done_items;
    int burst;
    int gap;
    int sel;
    int btn_pct;
    done_items = 0;
    while (done_items < n_items) begin
      burst   = $urandom_range(1, 24);
      sel     = $urandom_range(0, 2);
      btn_pct = (sel == 0) ? 2 : (sel == 1) ? 20 : 60;
      repeat (burst) begin
        random_pass(btn_pct);
        done_items++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.phone_present = 1'b0;
    in_ch.button_press  = 1'b0;
    in_ch.now_us        = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed passes on reset levels
    drive_pass(1'b0, 1'b0, 32'd0);
    drive_pass(1'b0, 1'b1, 32'd10);
    drive_pass(1'b0, 1'b0, 32'd20);
    drive_pass(1'b0, 1'b1, 32'd30);
    drive_pass(1'b1, 1'b1, 32'd40);           // mid: button beats phone
    drive_pass(1'b1, 1'b1, 32'd50);           // low: button beats phone
    drive_pass(1'b1, 1'b1, 32'd60);           // off: phone beats button
    drive_pass(1'b1, 1'b1, 32'hFFFF_FFFF);
    drive_pass(1'b0, 1'b0, 32'd100);
    drive_pass(1'b0, 1'b0, 32'd10_000_100);   // wait equals timeout, no switch-off
    drive_pass(1'b0, 1'b0, 32'd10_000_101);   // timeout passed, forced press
    drive_pass(1'b1, 1'b0, 32'd200);
    drive_pass(1'b0, 1'b0, 32'hFFFF_FF00);
    drive_pass(1'b0, 1'b0, 32'h0098_9600);    // wait wraps around zero
    drive_pass(1'b0, 1'b1, 32'd300);
    drive_pass(1'b1, 1'b0, 32'd310);
    drive_pass(1'b0, 1'b0, 32'd320);
    drive_pass(1'b1, 1'b0, 32'd330);
    drive_pass(1'b0, 1'b0, 32'd340);
    drive_pass(1'b0, 1'b1, 32'd350);
    clock_us = 32'd350;
    drain();

    set_regs(8'd0, 8'd255, 8'd0, 31'd0);
    run_random(150);
    drain();

    set_regs(8'($urandom), 8'($urandom), 8'($urandom), 31'd37);
    hold_req = 1'b1;
    run_random(150);
    drain();

    set_regs(8'd255, 8'd0, 8'd128, 31'h7FFF_FFFF);
    run_random(75);
    drain();
    run_random(75);
    drain();

    set_regs(8'($urandom), 8'($urandom), 8'($urandom), 31'($urandom_range(1000, 100000)));
    run_random(150);
    drain();

    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
